/* design/wnnc_pkg.sv */
// Shared types and constants for the weighted nearest-neighbour classifier.
`timescale 1ns / 1ps
`default_nettype none
package wnnc_pkg;

  localparam logic [1:0] KIND_WEIGHT     = 2'd0;
  localparam logic [1:0] KIND_TRAIN_ATTR = 2'd1;
  localparam logic [1:0] KIND_TRAIN_CLS  = 2'd2;
  localparam logic [1:0] KIND_QUERY      = 2'd3;

  localparam logic [1:0] CFG_ATTR_COUNT  = 2'd0;
  localparam logic [1:0] CFG_TRAIN_COUNT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd2;

  localparam int DIST_W = 52;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  sample_index;
    logic [5:0]  attr_index;
    logic [15:0] value;
    logic [7:0]  class_label;
    logic        exclude_enable;
    logic [9:0]  exclude_index;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        predicted_class;
    logic [DIST_W-1:0] min_distance;
    logic [9:0]        best_index;
    logic              hit;
    logic              no_candidate;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // apply the accepted load/query word
    logic start;       // latch query context, clear search state
    logic sample_begin;// clear accumulator for a new sample
    logic mac;         // issue one attribute read/accumulate
    logic sample_end;  // compare finished sample against best
    logic finish;      // build result word
  } wnnc_cmd_t;

endpackage
`default_nettype wire

/* design/weighted_nearest_neighbour_classifier.sv */
// Top level of the weighted 1-nearest-neighbour classifier.
`timescale 1ns / 1ps
`default_nettype none
// Words of kind 0..2 load weights, training attributes and class labels; kind 3
// words load query attributes, and a kind 3 word with last set starts a search
// over samples 0..train_count-1 and yields one result word. A search walks
// every sample through one shared multiply-accumulate unit fed from
// single-port stores, one attribute per cycle; the input is held off until the
// result word is taken. Each output word carries class, distance (2^45 = 1.0,
// saturating at 2^52-1), index, a hit flag and a no-candidate flag. The stores
// hold no reset value: read nothing before writing it. Write configuration only
// while idle.
module weighted_nearest_neighbour_classifier #(
  parameter int MAX_TRAIN = 1024,
  parameter int MAX_ATTR  = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire wnnc_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output wnnc_pkg::out_word_t    out_data,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_index,
  input  wire [15:0]             cfg_data
);
  import wnnc_pkg::*;

  localparam int SW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
  localparam int AW = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1;

  logic [6:0]  attr_count_r;
  logic [10:0] train_count_r;
  logic [15:0] threshold_r;

  // hold configuration; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r  <= 7'd64;
      train_count_r <= 11'd1;
      threshold_r   <= 16'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTR_COUNT:  attr_count_r  <= cfg_data[6:0];
        CFG_TRAIN_COUNT: train_count_r <= cfg_data[10:0];
        CFG_THRESHOLD:   threshold_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  wnnc_cmd_t     cmd;
  logic [SW-1:0] sample_idx;
  logic [AW-1:0] attr_idx;
  logic          skip_sample;

  wnnc_ctrl #(.MAX_TRAIN(MAX_TRAIN), .MAX_ATTR(MAX_ATTR)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_word(in_data), .in_ready,
    .out_valid, .out_ready,
    .attr_count(attr_count_r), .train_count(train_count_r),
    .cmd, .sample_idx, .attr_idx, .skip_sample
  );

  wnnc_datapath #(.MAX_TRAIN(MAX_TRAIN), .MAX_ATTR(MAX_ATTR)) u_dp (
    .clk, .in_word(in_data), .cmd, .sample_idx, .attr_idx, .skip_sample,
    .threshold(threshold_r), .result(out_data)
  );

  // never ready for input while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // result word stays stable while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a search start never coincides with a finishing result
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && cmd.finish)) else $error("start and finish together");
endmodule
`default_nettype wire

/* design/wnnc_datapath.sv */
// Datapath: stores, multiply-accumulate pipeline and best-match tracking.
`timescale 1ns / 1ps
`default_nettype none
module wnnc_datapath #(
  parameter int MAX_TRAIN = 1024,
  parameter int MAX_ATTR  = 64,
  localparam int SW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1,
  localparam int AW = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1
) (
  input  wire                  clk,
  input  wire wnnc_pkg::in_word_t  in_word,
  input  wire wnnc_pkg::wnnc_cmd_t cmd,
  input  wire [SW-1:0]         sample_idx,
  input  wire [AW-1:0]         attr_idx,
  input  wire                  skip_sample,
  input  wire [15:0]           threshold,
  output wnnc_pkg::out_word_t  result
);
  import wnnc_pkg::*;

  // training store addressed by {sample, attribute}
  localparam int TDEPTH = 1 << (SW + AW);

  logic [15:0] weight_mem [MAX_ATTR];
  logic [15:0] query_mem  [MAX_ATTR];
  logic [15:0] train_mem  [TDEPTH];
  logic [7:0]  class_mem  [MAX_TRAIN];

  logic        sidx_ok, aidx_ok;
  assign sidx_ok = 32'(in_word.sample_index) < 32'(MAX_TRAIN);
  assign aidx_ok = 32'(in_word.attr_index) < 32'(MAX_ATTR);

  logic [SW-1:0] wr_s;
  logic [AW-1:0] wr_a;
  assign wr_s = SW'(in_word.sample_index);
  assign wr_a = AW'(in_word.attr_index);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (in_word.kind)
        KIND_WEIGHT:     if (aidx_ok) weight_mem[wr_a] <= in_word.value;
        KIND_TRAIN_ATTR: if (sidx_ok && aidx_ok) train_mem[{wr_s, wr_a}] <= in_word.value;
        KIND_TRAIN_CLS:  if (sidx_ok) class_mem[wr_s] <= in_word.class_label;
        KIND_QUERY:      if (aidx_ok) query_mem[wr_a] <= in_word.value;
        default: ;
      endcase
    end
  end

  // stage 1: registered memory reads
  logic [15:0] w_r, q_r, t_r;
  logic        v1_r, v2_r, v3_r;
  always_ff @(posedge clk) begin
    w_r  <= weight_mem[attr_idx];
    q_r  <= query_mem[attr_idx];
    t_r  <= train_mem[{sample_idx, attr_idx}];
    v1_r <= cmd.mac;
  end

  // stage 2: difference squared and gate; a dropped attribute contributes nothing
  logic [15:0] d;
  assign d = (t_r >= q_r) ? (t_r - q_r) : (q_r - t_r);
  logic [31:0] dsq_r;
  logic [15:0] w2_r;
  always_ff @(posedge clk) begin
    dsq_r <= (w_r < threshold) ? 32'd0 : 32'(d) * 32'(d);
    w2_r  <= (w_r < threshold) ? 16'd0 : w_r;
    v2_r  <= v1_r;
  end

  // stage 3: weight multiply
  logic [47:0] term_r;
  always_ff @(posedge clk) begin
    term_r <= 48'(w2_r) * 48'(dsq_r);
    v3_r   <= v2_r;
  end

  // stage 4: saturating accumulate
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W:0]   sum;
  assign sum = {1'b0, acc_r} + (DIST_W+1)'(term_r);
  always_ff @(posedge clk) begin
    if (cmd.sample_begin) acc_r <= '0;
    else if (v3_r) acc_r <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  // best tracking
  logic              found_r;
  logic [DIST_W-1:0] best_d_r;
  logic [SW-1:0]     best_s_r;
  logic [7:0]        true_cls_r;
  logic [7:0]        best_cls_r;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r    <= 1'b0;
      true_cls_r <= in_word.class_label;
    end else if (cmd.sample_end && !skip_sample && (!found_r || acc_r < best_d_r)) begin
      found_r  <= 1'b1;
      best_d_r <= acc_r;
      best_s_r <= sample_idx;
    end
    best_cls_r <= class_mem[best_s_r];
    if (cmd.finish) begin
      result.no_candidate    <= !found_r;
      result.predicted_class <= found_r ? best_cls_r : 8'd0;
      result.min_distance    <= found_r ? best_d_r : '0;
      result.best_index      <= found_r ? 10'(best_s_r) : 10'd0;
      result.hit             <= found_r && (best_cls_r == true_cls_r);
    end
  end
endmodule
`default_nettype wire

/* design/wnnc_ctrl.sv */
// Controller: sequences loads, the sample/attribute walk and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module wnnc_ctrl #(
  parameter int MAX_TRAIN = 1024,
  parameter int MAX_ATTR  = 64,
  localparam int SW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1,
  localparam int AW = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire wnnc_pkg::in_word_t in_word,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire [6:0]             attr_count,
  input  wire [10:0]            train_count,
  output wnnc_pkg::wnnc_cmd_t   cmd,
  output logic [SW-1:0]         sample_idx,
  output logic [AW-1:0]         attr_idx,
  output logic                  skip_sample
);
  import wnnc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_FIN2  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam int CW = $clog2(MAX_TRAIN + 1) > 11 ? $clog2(MAX_TRAIN + 1) : 11;
  localparam int NW = $clog2(MAX_ATTR + 1) > 7 ? $clog2(MAX_ATTR + 1) : 7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] s_r, s_nxt, nt_r, nt_nxt;
  logic [NW-1:0] a_r, a_nxt, na_r, na_nxt;
  logic [1:0]    dr_r, dr_nxt;
  logic          ex_en_r;
  logic [9:0]    ex_idx_r;

  logic accept;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign accept    = in_valid && in_ready;
  assign sample_idx = s_r[SW-1:0];
  assign attr_idx   = a_r[AW-1:0];
  assign skip_sample = ex_en_r && (CW'(ex_idx_r) == s_r);

  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r; a_nxt = a_r; dr_nxt = dr_r;
    na_nxt = na_r; nt_nxt = nt_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept && in_word.kind == KIND_QUERY && in_word.last) begin
          cmd.start = 1'b1;
          na_nxt = (32'(attr_count) > 32'(MAX_ATTR)) ? NW'(MAX_ATTR) : NW'(attr_count);
          nt_nxt = (32'(train_count) > 32'(MAX_TRAIN)) ? CW'(MAX_TRAIN) : CW'(train_count);
          s_nxt = '0;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (s_r >= nt_r) state_nxt = ST_FIN;
        else begin
          cmd.sample_begin = 1'b1;
          a_nxt = '0;
          state_nxt = (na_r == '0) ? ST_CMP : ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (a_r + 1'b1 == na_r) begin
          dr_nxt = 2'd0;
          state_nxt = ST_DRAIN;
        end else a_nxt = a_r + 1'b1;
      end
      ST_DRAIN: begin
        dr_nxt = dr_r + 1'b1;
        if (dr_r == 2'd3) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.sample_end = 1'b1;
        s_nxt = s_r + 1'b1;
        state_nxt = ST_INIT;
      end
      ST_FIN:  state_nxt = ST_FIN2;
      ST_FIN2: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
    s_r <= s_nxt; a_r <= a_nxt; dr_r <= dr_nxt;
    na_r <= na_nxt; nt_r <= nt_nxt;
    if (cmd.start) begin
      ex_en_r  <= in_word.exclude_enable;
      ex_idx_r <= in_word.exclude_index;
    end
  end
endmodule
`default_nettype wire
